>>> hw/rtl/acss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acss_pkg
// Shared types and constants of the channel scan sequencer.
// ----------------------------------------------------------------------------
package acss_pkg;

  localparam int unsigned ChannelCount = 4;
  localparam int unsigned ChanWidth    = 2;
  localparam int unsigned ChanSlots    = 1 << ChanWidth;
  localparam int unsigned QueryWidth   = 3;

  localparam int unsigned TimeWidth    = 32;
  localparam int unsigned WaitWidth    = 16;
  localparam int unsigned BaseWidth    = 12;
  localparam int unsigned SampleWidth  = 16;
  localparam int unsigned ScaledWidth  = 12;
  localparam int unsigned CfgDataWidth = 16;

  localparam logic [WaitWidth-1:0]   WaitReset = 16'd3000;
  localparam logic [BaseWidth-1:0]   BaseReset = 12'h3E3;
  localparam logic [SampleWidth-1:0] StartBit  = 16'h8000;
  localparam logic [SampleWidth-1:0] MuxBase   = 16'h4000;

  localparam logic [ChanWidth-1:0] LastChannel = ChanWidth'(ChannelCount - 1);

  typedef enum logic [0:0] {
    CFG_CONVERSION_WAIT = 1'b0,
    CFG_BASE_BITS       = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [WaitWidth-1:0] conversion_wait_us;
    logic [BaseWidth-1:0] base_config_bits;
  } cfg_t;

  typedef struct packed {
    logic [TimeWidth-1:0]   now_us;
    logic [SampleWidth-1:0] adc_reading;
    logic [QueryWidth-1:0]  query_channel;
  } item_t;

  typedef struct packed {
    logic                   read_taken;
    logic                   start_issued;
    logic [SampleWidth-1:0] start_word;
    logic [ChanWidth-1:0]   scan_channel;
    logic                   scan_busy;
    logic [SampleWidth-1:0] query_raw;
    logic [ScaledWidth-1:0] query_scaled;
  } result_t;

  // Start word: start bit, mux code for a single-ended channel, base bits.
  function automatic logic [SampleWidth-1:0] make_start_word(
    input logic [ChanWidth-1:0] ch,
    input logic [BaseWidth-1:0] base
  );
    logic [SampleWidth-1:0] mux;
    mux = MuxBase + {2'b00, ch, 12'h000};
    return StartBit | mux | {4'h0, base};
  endfunction

endpackage

>>> hw/rtl/acss_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acss_cfg_regs
// Configuration register file: conversion wait time and start word base bits.
// ----------------------------------------------------------------------------
module acss_cfg_regs
  import acss_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  cfg_index_t              cfg_index,
  input  logic [CfgDataWidth-1:0] cfg_data,
  output cfg_t                    cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.conversion_wait_us <= WaitReset;
      cfg.base_config_bits   <= BaseReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CONVERSION_WAIT: cfg.conversion_wait_us <= cfg_data[WaitWidth-1:0];
        CFG_BASE_BITS:       cfg.base_config_bits   <= cfg_data[BaseWidth-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/acss_scan_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acss_scan_core
// Scan state, per-channel result store and the per-update decision logic.
// ----------------------------------------------------------------------------
module acss_scan_core
  import acss_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  item_t   item,
  input  logic    advance,
  output result_t res_next
);

  logic                   scan_active, scan_active_next;
  logic [ChanWidth-1:0]   current_channel, current_channel_next;
  logic [TimeWidth-1:0]   start_time, start_time_next;
  logic [SampleWidth-1:0] channel_results [ChanSlots];

  logic [TimeWidth-1:0]   elapsed;
  logic                   wait_done;
  logic                   capture;
  logic [ChanWidth-1:0]   query_idx;
  logic [SampleWidth-1:0] stored;
  logic [SampleWidth-1:0] raw;

  assign elapsed   = item.now_us - start_time;
  assign wait_done = elapsed >= {{(TimeWidth-WaitWidth){1'b0}}, cfg.conversion_wait_us};
  assign capture   = scan_active && wait_done;
  assign query_idx = item.query_channel[ChanWidth-1:0];

  always_comb begin
    scan_active_next     = scan_active;
    current_channel_next = current_channel;
    start_time_next      = start_time;
    res_next.start_issued = 1'b0;
    res_next.start_word   = '0;
    if (!scan_active) begin
      scan_active_next      = 1'b1;
      current_channel_next  = '0;
      start_time_next       = item.now_us;
      res_next.start_issued = 1'b1;
      res_next.start_word   = make_start_word('0, cfg.base_config_bits);
    end else if (wait_done) begin
      if (current_channel != LastChannel) begin
        current_channel_next  = current_channel + 1'b1;
        start_time_next       = item.now_us;
        res_next.start_issued = 1'b1;
        res_next.start_word   = make_start_word(current_channel + 1'b1,
                                                cfg.base_config_bits);
      end else begin
        scan_active_next     = 1'b0;
        current_channel_next = '0;
      end
    end

    // The query sees the store as it stands after this update.
    if (capture && (query_idx == current_channel)) begin
      stored = item.adc_reading;
    end else begin
      stored = channel_results[query_idx];
    end
    raw = (item.query_channel < QueryWidth'(ChannelCount)) ? stored : '0;

    res_next.read_taken   = capture;
    res_next.scan_channel = scan_active_next ? current_channel_next : '0;
    res_next.scan_busy    = scan_active_next;
    res_next.query_raw    = raw;
    res_next.query_scaled = raw[SampleWidth-1] ? '0 : raw[SampleWidth-1:4];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_active     <= 1'b0;
      current_channel <= '0;
      start_time      <= '0;
      for (int i = 0; i < ChanSlots; i++) begin
        channel_results[i] <= '0;
      end
    end else if (advance) begin
      scan_active     <= scan_active_next;
      current_channel <= current_channel_next;
      start_time      <= start_time_next;
      if (capture) begin
        channel_results[current_channel] <= item.adc_reading;
      end
    end
  end

endmodule

>>> hw/rtl/adc_channel_scan_sequencer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_channel_scan_sequencer_unit
// Round-robin scan sequencer for a single-shot converter with a result store.
// ----------------------------------------------------------------------------
// An accepted input beat passes through the input register and then the
// result register. Throughput: one beat per cycle while the result side is
// not stalling, set by the single update stage between the two registers.
// Reset (synchronous, active high): scan idle, channel 0, start time 0, all
// stored results zero, registers at their reset values, both stages empty.
// ----------------------------------------------------------------------------
module adc_channel_scan_sequencer_unit
  import acss_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,

  // Configuration write channel.
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  cfg_index_t              cfg_index,
  input  logic [CfgDataWidth-1:0] cfg_data,

  // Update items.
  input  logic                    item_valid,
  output logic                    item_stall,
  input  logic [TimeWidth-1:0]    now_us,
  input  logic [SampleWidth-1:0]  adc_reading,
  input  logic [QueryWidth-1:0]   query_channel,

  // Result items.
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic                    read_taken,
  output logic                    start_issued,
  output logic [SampleWidth-1:0]  start_word,
  output logic [ChanWidth-1:0]    scan_channel,
  output logic                    scan_busy,
  output logic [SampleWidth-1:0]  query_raw,
  output logic [ScaledWidth-1:0]  query_scaled
);

  cfg_t    cfg;
  item_t   stage_item;
  logic    stage_valid;
  result_t res_next;
  result_t res;
  logic    res_free;
  logic    advance;
  logic    accept;

  acss_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The result register frees up either when it is empty or when its beat is
  // taken this cycle, so the input stage only holds while a result waits and
  // the downstream side is stalling.
  assign res_free   = !result_valid || !result_stall;
  assign advance    = stage_valid && res_free;
  assign item_stall = stage_valid && !res_free;
  assign accept     = item_valid && !item_stall;

  // Input register: holds one beat until the update logic may commit it.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_item.now_us        <= now_us;
      stage_item.adc_reading   <= adc_reading;
      stage_item.query_channel <= query_channel;
    end
  end

  // The scan state only moves when the staged beat is committed into the
  // result register, so a stall never repeats or loses an update.
  acss_scan_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .item     (stage_item),
    .advance  (advance),
    .res_next (res_next)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign read_taken   = res.read_taken;
  assign start_issued = res.start_issued;
  assign start_word   = res.start_word;
  assign scan_channel = res.scan_channel;
  assign scan_busy    = res.scan_busy;
  assign query_raw    = res.query_raw;
  assign query_scaled = res.query_scaled;

endmodule
